@@ rtl/dma_window_permission_table_macros.svh @@
// assertion macros for the dma window permission table checker
`ifndef DMA_WINDOW_PERMISSION_TABLE_MACROS_SVH
`define DMA_WINDOW_PERMISSION_TABLE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define DWPT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define DWPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dwpt_pkg.sv @@
// ----------------------------------------------------------------------------
// dwpt_pkg
// types, constants and codes shared by the dma window permission table
// ----------------------------------------------------------------------------
`default_nettype none
package dwpt_pkg;
    localparam int WINDOWS     = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int ADDR_BITS   = 56;
    localparam int DEVICE_BITS = 24;
    localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
    localparam int SLOT_BITS   = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int COUNT_BITS  = 5;
    localparam int PERM_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    // window record as stored in the table memory
    localparam int ENTRY_BITS = DEVICE_BITS + 2 * ADDR_BITS + PERM_BITS;

    typedef enum logic [1:0] {
        REQ_MAP   = 2'd0,
        REQ_UNMAP = 2'd1,
        REQ_CHECK = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVAL    = 3'd1,
        ST_BAD_CAP  = 3'd2,
        ST_FULL     = 3'd3,
        ST_RIGHTS   = 3'd4
    } status_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD_MASK  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STORE_MASK = 1'b1;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [23:0]            dev_id;
        logic [55:0]            addr;
        logic [55:0]            length;
        logic [15:0]            perms;
        logic                   write_access;
        logic                   cap_type_ok;
        logic                   cap_valid;
        logic                   cap_tag;
        logic [55:0]            cap_start;
        logic [55:0]            cap_len;
        logic [15:0]            cap_rights;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       allowed;
        logic [4:0] used_windows;
    } rsp_t;

    typedef struct packed {
        logic [DEVICE_BITS-1:0] device;
        logic [ADDR_BITS-1:0]   base;
        logic [ADDR_BITS-1:0]   size;
        logic [PERM_BITS-1:0]   perms;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic                 load_req;   // capture the accepted item
        logic                 rd_en;      // read one slot
        logic [SLOT_BITS-1:0] rd_slot;
        logic                 eval;       // slot data valid, evaluate it
        logic                 do_write;   // store window into free slot
        logic                 do_clear;   // clear matched slot
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_type_t kind;
        status_t   precheck;    // map checks before scan, ST_OK if passed
        logic      hit;         // evaluated slot matches
        logic      free_found;  // a free slot is known
    } sts_t;
endpackage
`default_nettype wire

@@ rtl/dwpt_if.sv @@
// ----------------------------------------------------------------------------
// dwpt_req_if / dwpt_rsp_if
// valid/ready channels carrying request and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface dwpt_req_if;
    import dwpt_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dwpt_rsp_if;
    import dwpt_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/dwpt_ram.sv @@
// ----------------------------------------------------------------------------
// dwpt_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module dwpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/dwpt_datapath.sv @@
// ----------------------------------------------------------------------------
// dwpt_datapath
// request register, window memory, valid bits, range compares and result
// ----------------------------------------------------------------------------
`default_nettype none
module dwpt_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dwpt_pkg::req_t             req,
    input  wire dwpt_pkg::cmd_t             cmd,
    input  wire logic                       cfg_we,
    input  wire logic [dwpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                cfg_data,
    output dwpt_pkg::sts_t                  sts,
    output dwpt_pkg::rsp_t                  rsp
);
    import dwpt_pkg::*;

    req_t                  req_reg;
    logic [WINDOWS-1:0]    valid_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [15:0]           load_mask_reg;
    logic [15:0]           store_mask_reg;
    logic [SLOT_BITS-1:0]  eval_slot_reg;
    logic [SLOT_BITS-1:0]  free_slot_reg;
    logic                  free_found_reg;
    logic [SLOT_BITS-1:0]  hit_slot_reg;
    logic                  allowed_reg;
    logic [WINDOWS-1:0]    valid_next;
    logic [COUNT_BITS-1:0] count_next;

    entry_t                rd_entry;
    logic [ENTRY_BITS-1:0] rd_bits;
    entry_t                wr_entry;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [ADDR_BITS-1:0]  r_len;
    logic [DEVICE_BITS-1:0] r_dev;
    logic [ADDR_BITS:0]    req_end;
    logic [ADDR_BITS:0]    win_end;
    logic [ADDR_BITS:0]    cap_end;
    logic                  slot_valid;
    logic                  dev_match;
    logic                  contains;
    logic                  hit;
    logic [15:0]           need;
    status_t               precheck;

    assign r_addr = req_reg.addr[ADDR_BITS-1:0];
    assign r_len  = req_reg.length[ADDR_BITS-1:0];
    assign r_dev  = req_reg.dev_id[DEVICE_BITS-1:0];

    // window memory
    assign wr_entry.device = r_dev;
    assign wr_entry.base   = r_addr;
    assign wr_entry.size   = r_len;
    assign wr_entry.perms  = req_reg.perms;

    dwpt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(WINDOWS)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.do_write),
        .wr_addr (free_slot_reg),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_slot),
        .rd_data (rd_bits)
    );
    assign rd_entry = entry_t'(rd_bits);

    // slot evaluation
    assign slot_valid = valid_reg[eval_slot_reg];
    assign dev_match  = rd_entry.device == r_dev;
    assign req_end    = {1'b0, r_addr} + {1'b0, r_len};
    assign win_end    = {1'b0, rd_entry.base} + {1'b0, rd_entry.size};
    assign contains   = (r_addr >= rd_entry.base) && (req_end <= win_end);
    assign need       = req_reg.write_access ? store_mask_reg : load_mask_reg;

    always_comb
    begin
        case (req_type_t'(req_reg.req_type))
            REQ_UNMAP: hit = slot_valid && dev_match && (rd_entry.base == r_addr);
            REQ_CHECK: hit = slot_valid && dev_match && contains;
            default:   hit = 1'b0;
        endcase
    end

    // map checks ahead of the scan
    assign cap_end = {1'b0, req_reg.cap_start[ADDR_BITS-1:0]}
                   + {1'b0, req_reg.cap_len[ADDR_BITS-1:0]};

    always_comb
    begin
        if (!req_reg.cap_type_ok || !req_reg.cap_valid || !req_reg.cap_tag)
            precheck = ST_BAD_CAP;
        else if ((r_addr[PAGE_BITS-1:0] != '0) || (r_len[PAGE_BITS-1:0] != '0))
            precheck = ST_INVAL;
        else if (count_reg >= COUNT_BITS'(WINDOWS))
            precheck = ST_FULL;
        else if ((r_addr < req_reg.cap_start[ADDR_BITS-1:0]) || (req_end > cap_end))
            precheck = ST_INVAL;
        else if ((req_reg.perms & ~req_reg.cap_rights) != '0)
            precheck = ST_RIGHTS;
        else
            precheck = ST_OK;
    end

    assign sts.kind       = req_type_t'(req_reg.req_type);
    assign sts.precheck   = precheck;
    assign sts.hit        = hit;
    assign sts.free_found = free_found_reg;

    // request capture, slot tracking and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.rd_en)
        begin
            eval_slot_reg <= cmd.rd_slot;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.do_write)
        begin
            valid_next[free_slot_reg] = 1'b1;
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (cmd.do_clear)
        begin
            valid_next[hit_slot_reg] = 1'b0;
            if (count_reg != '0)
                count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            load_mask_reg  <= 16'd1;
            store_mask_reg <= 16'd2;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            hit_slot_reg   <= '0;
            allowed_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOAD_MASK:  load_mask_reg  <= cfg_data;
                    CFG_STORE_MASK: store_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load_req)
            begin
                free_found_reg <= 1'b0;
                allowed_reg    <= 1'b0;
            end
            else if (cmd.eval)
            begin
                // first free slot, valid bits only
                if (!free_found_reg && !slot_valid)
                begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= eval_slot_reg;
                end
                if (hit)
                begin
                    hit_slot_reg <= eval_slot_reg;
                    allowed_reg  <= (rd_entry.perms & need) != '0;
                end
            end
        end
    end

    assign rsp.allowed      = allowed_reg;
    assign rsp.used_windows = count_reg;
    assign rsp.status       = '0;
endmodule
`default_nettype wire

@@ rtl/dwpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// dwpt_ctrl
// sequencer: accept, decide, slot scan, commit, result handoff
// ----------------------------------------------------------------------------
`default_nettype none
module dwpt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire dwpt_pkg::sts_t  sts,
    output dwpt_pkg::cmd_t       cmd,
    output logic [2:0]           status,
    output logic                 allowed_en
);
    import dwpt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_BITS:0]   slot_reg, slot_next;
    logic                 pend_reg, pend_next;   // read in flight
    logic [2:0]           status_reg, status_next;
    logic                 keep_reg, keep_next;   // allowed bit is meaningful
    logic                 last_rd;

    assign last_rd   = slot_reg == (SLOT_BITS+1)'(WINDOWS);
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign status    = status_reg;
    assign allowed_en = keep_reg;

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        keep_next   = keep_reg;
        cmd         = '0;
        cmd.rd_slot = slot_reg[SLOT_BITS-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                slot_next = '0;
                keep_next = 1'b0;
                case (sts.kind)
                    REQ_MAP:
                    begin
                        status_next = sts.precheck;
                        state_next  = (sts.precheck == ST_OK) ? S_SCAN : S_OUT;
                    end
                    REQ_UNMAP:
                    begin
                        status_next = ST_INVAL;
                        state_next  = S_SCAN;
                    end
                    REQ_CHECK:
                    begin
                        status_next = ST_OK;
                        state_next  = S_SCAN;
                    end
                    default:
                    begin
                        status_next = ST_INVAL;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_SCAN:
            begin
                // evaluate slot read last cycle, issue next read
                cmd.eval = pend_reg;
                if (pend_reg && sts.hit)
                begin
                    if (sts.kind == REQ_UNMAP)
                    begin
                        status_next = ST_OK;
                        state_next  = S_COMMIT;
                    end
                    else
                    begin
                        keep_next  = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else if (pend_reg && sts.kind == REQ_MAP && !sts.free_found)
                begin
                    // free slot is known in the cycle after its evaluation
                    state_next = S_SCAN;
                    slot_next  = slot_reg;
                    if (last_rd)
                        state_next = S_COMMIT;
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        pend_next = 1'b1;
                        slot_next = slot_reg + (SLOT_BITS+1)'(1);
                    end
                end
                else if (sts.kind == REQ_MAP && sts.free_found)
                    state_next = S_COMMIT;
                else if (last_rd)
                    state_next = (sts.kind == REQ_MAP) ? S_COMMIT : S_OUT;
                else
                begin
                    cmd.rd_en = 1'b1;
                    pend_next = 1'b1;
                    slot_next = slot_reg + (SLOT_BITS+1)'(1);
                end
            end
            S_COMMIT:
            begin
                if (sts.kind == REQ_MAP)
                begin
                    if (sts.free_found)
                    begin
                        cmd.do_write = 1'b1;
                        status_next  = ST_OK;
                    end
                    else
                        status_next  = ST_FULL;
                end
                else
                    cmd.do_clear = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            slot_reg   <= '0;
            pend_reg   <= 1'b0;
            status_reg <= '0;
            keep_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
            keep_reg   <= keep_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/dma_window_permission_table.sv @@
// ----------------------------------------------------------------------------
// dma_window_permission_table
// dma window table with map, unmap and access check requests
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req.valid/ready    req_t request fields
//  rsp      out  rsp.valid/ready    status, allowed, used_windows
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// one item at a time: rejected maps and unknown requests skip the slot scan;
// other requests scan the window memory through its read port, one slot per
// cycle. reset empties the table at once via per-slot valid bits. req.ready
// stays low until the result has been taken.
`default_nettype none
module dma_window_permission_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    dwpt_req_if.sink                               req,
    dwpt_rsp_if.source                             rsp,
    input  wire logic                              cfg_we,
    input  wire logic [dwpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [15:0]                       cfg_data
);
    import dwpt_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    rsp_t       dp_rsp;
    logic [2:0] status;
    logic       allowed_en;

    dwpt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.payload),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .rsp       (dp_rsp)
    );

    dwpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .sts        (sts),
        .cmd        (cmd),
        .status     (status),
        .allowed_en (allowed_en)
    );

    // result assembly
    assign rsp.payload.status       = status | dp_rsp.status;
    assign rsp.payload.allowed      = allowed_en & dp_rsp.allowed;
    assign rsp.payload.used_windows = dp_rsp.used_windows;
endmodule
`default_nettype wire

@@ rtl/dwpt_checker.sv @@
// ----------------------------------------------------------------------------
// dwpt_checker
// port-level checks on the dma window permission table
// ----------------------------------------------------------------------------
`default_nettype none
`include "dma_window_permission_table_macros.svh"
module dwpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic        rsp_allowed,
    input wire logic [4:0]  rsp_used
);
    import dwpt_pkg::*;

    // a result stays until taken
    `DWPT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
    // no new item while a result waits
    `DWPT_ASSERT_IMPL(a_one_item, clk, rst_n, rsp_valid, !req_ready, "item accepted early")
    // permitted access only with ok status
    `DWPT_ASSERT_IMPL(a_allow_ok, clk, rst_n, rsp_valid && rsp_allowed, rsp_status == ST_OK,
        "allowed with error")
    // status and count in range
    `DWPT_ASSERT_IMPL(a_range, clk, rst_n, rsp_valid,
        (rsp_status <= ST_RIGHTS) && (rsp_used <= 5'd16), "result out of range")
endmodule

bind dma_window_permission_table dwpt_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.payload.status),
    .rsp_allowed (rsp.payload.allowed),
    .rsp_used    (rsp.payload.used_windows)
);
`default_nettype wire

@@ tb/dwpt_tb_if.sv @@
// ----------------------------------------------------------------------------
// dwpt_tb_if
// testbench-side notes for the dma window table channels
// ----------------------------------------------------------------------------
// the request and result channels are the dwpt_req_if and dwpt_rsp_if
// interfaces of the design; this file holds the expected-result helper type
// used by the scoreboard
`default_nettype none
package dwpt_tb_pkg;
    import dwpt_pkg::*;

    // expected result of one request item
    typedef struct packed {
        logic [2:0] status;
        logic       allowed;
        logic [4:0] used_windows;
    } expected_rsp_t;
endpackage
`default_nettype wire

@@ tb/dwpt_checker.sv @@
// ----------------------------------------------------------------------------
// dwpt_scoreboard
// watches request and result items, predicts the table and compares results
// ----------------------------------------------------------------------------
`default_nettype none
module dwpt_scoreboard
    import dwpt_pkg::*;
    import dwpt_tb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    input  wire logic                    req_ready,
    input  wire req_t                    req_payload,
    input  wire logic                    rsp_valid,
    input  wire logic                    rsp_ready,
    input  wire rsp_t                    rsp_payload,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [15:0]             cfg_data,
    output int                           errors,
    output int                           pending
);
    // shadow of the window table
    logic                   win_valid [WINDOWS];
    logic [DEVICE_BITS-1:0] win_dev   [WINDOWS];
    logic [ADDR_BITS-1:0]   win_base  [WINDOWS];
    logic [ADDR_BITS-1:0]   win_size  [WINDOWS];
    logic [PERM_BITS-1:0]   win_perms [WINDOWS];
    int                     win_count;
    logic [15:0]            load_mask;
    logic [15:0]            store_mask;
    expected_rsp_t          expected_q [$];

    // map request: capability checks in order, then lowest free slot
    function automatic logic [2:0] map_window(req_t r);
        logic [ADDR_BITS:0] a_end;
        logic [ADDR_BITS:0] c_end;
        if (!r.cap_type_ok) return ST_BAD_CAP;
        if (!r.cap_valid || !r.cap_tag) return ST_BAD_CAP;
        if (r.addr[11:0] != 0 || r.length[11:0] != 0) return ST_INVAL;
        if (win_count >= WINDOWS) return ST_FULL;
        a_end = {1'b0, r.addr} + {1'b0, r.length};
        c_end = {1'b0, r.cap_start} + {1'b0, r.cap_len};
        if (r.addr < r.cap_start || a_end > c_end) return ST_INVAL;
        if ((r.perms & ~r.cap_rights) != 0) return ST_RIGHTS;
        for (int i = 0; i < WINDOWS; i++)
            if (!win_valid[i])
            begin
                win_valid[i] = 1'b1;
                win_dev[i]   = r.dev_id;
                win_base[i]  = r.addr;
                win_size[i]  = r.length;
                win_perms[i] = r.perms;
                win_count++;
                return ST_OK;
            end
        return ST_FULL;
    endfunction

    // unmap request: lowest valid slot with matching device and base
    function automatic logic [2:0] unmap_window(req_t r);
        for (int i = 0; i < WINDOWS; i++)
            if (win_valid[i] && win_dev[i] == r.dev_id && win_base[i] == r.addr)
            begin
                win_valid[i] = 1'b0;
                if (win_count > 0) win_count--;
                return ST_OK;
            end
        return ST_INVAL;
    endfunction

    // check request: first containing slot of the device decides
    function automatic logic access_allowed(req_t r);
        logic [ADDR_BITS:0] a_end;
        logic [ADDR_BITS:0] w_end;
        a_end = {1'b0, r.addr} + {1'b0, r.length};
        for (int i = 0; i < WINDOWS; i++)
        begin
            if (!win_valid[i] || win_dev[i] != r.dev_id) continue;
            w_end = {1'b0, win_base[i]} + {1'b0, win_size[i]};
            if (r.addr >= win_base[i] && a_end <= w_end)
                return (win_perms[i] & (r.write_access ? store_mask : load_mask)) != 0;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        expected_rsp_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOWS; i++) win_valid[i] = 1'b0;
            win_count  = 0;
            load_mask  = 16'd1;
            store_mask = 16'd2;
            errors     = 0;
            expected_q.delete();
        end
        else
        begin
            // compare result item with oldest expectation
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("result item with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp_payload.status !== e.status)
                        report_mismatch("status", rsp_payload.status, e.status);
                    if (rsp_payload.allowed !== e.allowed)
                        report_mismatch("allowed", rsp_payload.allowed, e.allowed);
                    if (rsp_payload.used_windows !== e.used_windows)
                        report_mismatch("used_windows", rsp_payload.used_windows,
                                        e.used_windows);
                end
            end
            // predict accepted request item
            if (req_valid && req_ready)
            begin
                e.allowed = 1'b0;
                e.status  = ST_INVAL;
                case (req_payload.req_type)
                    REQ_MAP:   e.status = map_window(req_payload);
                    REQ_UNMAP: e.status = unmap_window(req_payload);
                    REQ_CHECK:
                    begin
                        e.status  = ST_OK;
                        e.allowed = access_allowed(req_payload);
                    end
                    default: ;
                endcase
                e.used_windows = win_count[4:0];
                expected_q.push_back(e);
            end
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_LOAD_MASK) load_mask = cfg_data;
                else store_mask = cfg_data;
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the dma window permission table
// ----------------------------------------------------------------------------
// directed map, unmap and check items cover capability failures, alignment,
// bounds, rights, a full table and boundary accesses; random phases then mix
// well-formed map/check/unmap traffic with noise under varied idling
`default_nettype none
module tb;
    import dwpt_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_LOAD_MASK;
    logic [15:0]             cfg_data = '0;
    int                      errors;
    int                      pending;
    int                      cycles = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    // recently mapped windows, reused for checks and unmaps
    logic [23:0]             known_dev  [$];
    logic [55:0]             known_base [$];
    logic [55:0]             known_size [$];

    dwpt_req_if req_ch ();
    dwpt_rsp_if rsp_ch ();

    dma_window_permission_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dwpt_scoreboard u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_payload (req_ch.payload),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_payload (rsp_ch.payload),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [55:0] rand56();
        return 56'({$urandom(), $urandom()});
    endfunction

    // send one item, with random idle cycles ahead of it
    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        req_ch.valid <= 1'b0;
        // the block is busy for at least this cycle
        @(posedge clk);
    endtask

    // well-formed map item with capability covering the window
    function automatic req_t good_map(logic [23:0] dev);
        req_t r;
        r = '0;
        r.req_type    = REQ_MAP;
        r.dev_id      = dev;
        r.addr        = 56'({$urandom_range(1, 255), 12'h0}) << ($urandom_range(1) * 40);
        r.length      = 56'({$urandom_range(0, 64), 12'h0});
        r.perms       = 16'($urandom());
        r.cap_type_ok = 1'b1;
        r.cap_valid   = 1'b1;
        r.cap_tag     = 1'b1;
        r.cap_start   = r.addr - 56'($urandom_range(0, 4096));
        r.cap_len     = r.length + (r.addr - r.cap_start) + 56'($urandom_range(0, 8192));
        r.cap_rights  = r.perms | 16'($urandom());
        return r;
    endfunction

    function automatic req_t random_item();
        req_t r;
        int k;
        int pick;
        r = '0;
        k = $urandom_range(99);
        if (k < 30)
        begin
            r = good_map(24'($urandom_range(0, 3)));
            if ($urandom_range(9) == 0) r.perms = 16'($urandom());
            if ($urandom_range(14) == 0) r.addr[$urandom_range(11)] = 1'b1;
            if ($urandom_range(19) == 0) r.cap_tag = 1'b0;
            if ($urandom_range(9) == 0)
            begin
                r.addr = rand56() & ~56'hfff;
                r.length = rand56() & ~56'hfff;
                r.cap_start = rand56();
                r.cap_len = rand56();
            end
            known_dev.push_back(r.dev_id);
            known_base.push_back(r.addr);
            known_size.push_back(r.length);
            if (known_dev.size() > 24)
            begin
                void'(known_dev.pop_front());
                void'(known_base.pop_front());
                void'(known_size.pop_front());
            end
        end
        else if (k < 80 && known_dev.size() > 0)
        begin
            pick = $urandom_range(known_dev.size() - 1);
            r.dev_id = known_dev[pick];
            if (k < 50)
            begin
                r.req_type = REQ_UNMAP;
                r.addr     = known_base[pick];
            end
            else
            begin
                r.req_type = REQ_CHECK;
                r.addr     = known_base[pick] + 56'($urandom_range(0, 4096));
                r.length   = 56'($urandom_range(0, 8192));
                if ($urandom_range(3) == 0)
                begin
                    r.addr   = known_base[pick];
                    r.length = known_size[pick];
                end
                r.write_access = 1'($urandom());
            end
        end
        else
        begin
            // noise over every field and bit
            r.req_type     = 2'($urandom());
            r.dev_id       = 24'($urandom());
            r.addr         = rand56();
            r.length       = rand56();
            r.perms        = 16'($urandom());
            r.write_access = 1'($urandom());
            r.cap_type_ok  = 1'($urandom());
            r.cap_valid    = 1'($urandom());
            r.cap_tag      = 1'($urandom());
            r.cap_start    = rand56();
            r.cap_len      = rand56();
            r.cap_rights   = 16'($urandom());
        end
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        req_t r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items
        send_idle_pct = 0;
        recv_idle_pct = 0;
        r = good_map(24'h000001);
        r.cap_type_ok = 1'b0;
        send_item(r);
        r.cap_type_ok = 1'b1;
        r.cap_valid = 1'b0;
        send_item(r);
        r.cap_valid = 1'b1;
        r.cap_tag = 1'b0;
        send_item(r);
        r.cap_tag = 1'b1;
        r.length[0] = 1'b1;
        send_item(r);
        r.length[0] = 1'b0;
        r.cap_start = r.addr + 56'h1000;
        send_item(r);
        r = good_map(24'h000001);
        r.cap_rights = r.perms & 16'h7fff;
        r.perms[15] = 1'b1;
        send_item(r);
        // one-page window at the top of the address space
        r = '0;
        r.req_type = REQ_MAP;
        r.dev_id = 24'hffffff;
        r.addr = 56'hffffffff_fff000;
        r.length = 56'h1000;
        r.perms = 16'hffff;
        r.cap_type_ok = 1'b1;
        r.cap_valid = 1'b1;
        r.cap_tag = 1'b1;
        r.cap_start = 56'hffffffff_fff000;
        r.cap_len = 56'hffffffffffffff;
        r.cap_rights = 16'hffff;
        send_item(r);
        // one-byte and zero-length accesses at the window end, and a write check
        r.req_type = REQ_CHECK;
        r.addr = 56'hffffffffffffff;
        r.length = 56'h1;
        send_item(r);
        r.addr = 56'hffffffff_fff000;
        r.length = 56'h1000;
        r.write_access = 1'b1;
        send_item(r);
        r.addr = 56'hffffffffffffff;
        r.length = '0;
        send_item(r);
        r.req_type = REQ_NONE;
        send_item(r);
        r.req_type = REQ_UNMAP;
        r.addr = 56'hffffffff_fff000;
        send_item(r);
        send_item(r);
        // fill past capacity with zero-length windows
        for (int i = 0; i < 17; i++)
        begin
            r = good_map(24'($urandom_range(0, 3)));
            r.length = '0;
            send_item(r);
        end
        drain();
        write_reg(CFG_LOAD_MASK, 16'hffff);
        write_reg(CFG_STORE_MASK, 16'h0000);

        // random phases under different idling and register settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 13; recv_idle_pct = 79; end
                1: begin send_idle_pct = 79; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < 200; n++) send_item(random_item());
            drain();
            write_reg(CFG_LOAD_MASK, 16'($urandom()));
            write_reg(CFG_STORE_MASK, (ph == 2) ? 16'h8000 : 16'($urandom()));
        end
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/dwpt_pkg.sv
rtl/dwpt_if.sv
rtl/dwpt_ram.sv
rtl/dwpt_datapath.sv
rtl/dwpt_ctrl.sv
rtl/dma_window_permission_table.sv
rtl/dwpt_checker.sv
tb/dwpt_tb_if.sv
tb/dwpt_checker.sv
tb/tb.sv
